FILE: src/mre_pkg.sv
package mre_pkg;

  localparam int COORD_W     = 16;  // pixel position width
  localparam int DIV_W       = 8;   // cell size width
  localparam int BTN_W       = 8;   // button number width
  localparam int POS_W       = 17;  // 1-based row or column
  localparam int SAVED_POS_W = 18;  // saved row or column, signed
  localparam int CODE_W      = 10;  // button code, signed
  localparam int BCD_DIGITS  = 5;
  localparam int BCD_W       = 4 * BCD_DIGITS;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int BYTE_W      = 8;

  localparam logic [BYTE_W-1:0] CH_ESC   = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;  // '['
  localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [BYTE_W-1:0] CH_UPM   = 8'h4D;  // 'M'
  localparam logic [BYTE_W-1:0] CH_LOWM  = 8'h6D;  // 'm'
  localparam logic [BYTE_W-1:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'

  localparam int CODE_OFS   = 32;  // legacy byte offset, also motion flag
  localparam int HIGH_BTN   = 3;   // first code that gets the high-button shift
  localparam int HIGH_SHIFT = 61;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MOTION  = 2'd2,
    EV_OTHER   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_WIDTH     = 3'd0,
    REG_CELL_HEIGHT    = 3'd1,
    REG_MOUSE_ENABLE   = 3'd2,
    REG_REPORT_PRESS   = 3'd3,
    REG_REPORT_RELEASE = 3'd4,
    REG_REPORT_MOTION  = 3'd5,
    REG_SGR_FORMAT     = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    F_BUTTON = 2'd0,
    F_COL    = 2'd1,
    F_ROW    = 2'd2
  } field_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_HEAD,
    S_LEGACY,
    S_CONV_GO,
    S_CONV_WAIT,
    S_SIGN,
    S_DIGITS,
    S_SEP
  } state_t;

  // handshake between the controller and a serial unit
  typedef struct packed {
    logic done;
  } unit_status_t;

endpackage

FILE: src/mouse_report_encoder_unit.sv
// Pointer event to terminal mouse report encoder. Each event that is
// accepted and enabled is divided down to a 1-based character cell by two
// bit-serial dividers and, when reported, turned into an escape sequence
// sent one byte per beat, tlast on the final byte. An event that is masked
// off or unsupported is taken without leaving idle and gives no output; a
// motion within the same cell gives no output either but waits for the
// division. The cell division starts in S_DIV_GO and yields 16 quotient
// bits, one per cycle. The legacy form then sends its 6 beats. The decimal
// form sends 3 header beats, a minus sign for a negative button code, then
// for each of the three numbers runs the 17-step serial binary-to-decimal
// converter, walks its 5 digits (leading zeros are skipped, not sent) and
// sends the separator or final byte. A stalled output adds its wait
// cycles. Only one event is worked on at a time; the next is accepted once
// the last byte has been loaded into the output register.
// Configuration registers: 0 cell_width, 1 cell_height, 2 mouse_enable,
// 3 report_press, 4 report_release, 5 report_motion, 6 sgr_format; write
// them only while no event is in progress.
module mouse_report_encoder_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [39:0]                         s_tdata,  // pointer_x, pointer_y, button_number
  input  logic [1:0]                          s_tuser,  // event_kind
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [7:0]                          m_tdata,  // out_byte
  output logic                                m_tlast,  // last_byte
  input  logic                                cfg_we,
  input  logic [mre_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mre_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int DCNT_W = $clog2(mre_pkg::BCD_DIGITS);

  // configuration
  logic [mre_pkg::DIV_W-1:0] cell_width;
  logic [mre_pkg::DIV_W-1:0] cell_height;
  logic                      mouse_enable;
  logic                      report_press;
  logic                      report_release;
  logic                      report_motion;
  logic                      sgr_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width     <= 8'd8;
      cell_height    <= 8'd16;
      mouse_enable   <= 1'b0;
      report_press   <= 1'b0;
      report_release <= 1'b0;
      report_motion  <= 1'b0;
      sgr_format     <= 1'b0;
    end else if (cfg_we) begin
      unique case (mre_pkg::cfg_reg_t'(cfg_index))
        mre_pkg::REG_CELL_WIDTH:     cell_width     <= cfg_data;
        mre_pkg::REG_CELL_HEIGHT:    cell_height    <= cfg_data;
        mre_pkg::REG_MOUSE_ENABLE:   mouse_enable   <= cfg_data[0];
        mre_pkg::REG_REPORT_PRESS:   report_press   <= cfg_data[0];
        mre_pkg::REG_REPORT_RELEASE: report_release <= cfg_data[0];
        mre_pkg::REG_REPORT_MOTION:  report_motion  <= cfg_data[0];
        mre_pkg::REG_SGR_FORMAT:     sgr_format     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mre_pkg::state_t                       state, state_next;
  logic [1:0]                            idx, idx_next;
  mre_pkg::field_t                       fsel, fsel_next;
  logic [DCNT_W-1:0]                     dcnt, dcnt_next;
  logic                                  started, started_next;
  logic [mre_pkg::BCD_W-1:0]             digits, digits_next;

  mre_pkg::kind_t                        kind_r;
  logic [mre_pkg::COORD_W-1:0]           px_r;
  logic [mre_pkg::COORD_W-1:0]           py_r;
  logic signed [mre_pkg::CODE_W-1:0]     code_r;
  logic [mre_pkg::POS_W-1:0]             col_r;
  logic [mre_pkg::POS_W-1:0]             row_r;

  logic signed [mre_pkg::SAVED_POS_W-1:0] saved_row;
  logic signed [mre_pkg::SAVED_POS_W-1:0] saved_col;
  logic signed [mre_pkg::CODE_W-1:0]      saved_button;

  mre_pkg::kind_t                        in_kind;
  logic [mre_pkg::BTN_W-1:0]             in_btn;
  logic signed [mre_pkg::CODE_W-1:0]     in_code;
  logic                                  in_accept;
  logic                                  accept_ok;

  logic                                  div_start;
  mre_pkg::unit_status_t                 x_status, y_status;
  logic [mre_pkg::COORD_W-1:0]           x_quo, y_quo;
  logic                                  div_done;
  logic [mre_pkg::DIV_W-1:0]             cw_eff, ch_eff;
  logic [mre_pkg::POS_W-1:0]             col_q, row_q;
  logic                                  same_cell;

  logic                                  bcd_start;
  mre_pkg::unit_status_t                 bcd_status;
  logic [mre_pkg::BCD_W-1:0]             bcd_val;
  logic [mre_pkg::POS_W-1:0]             conv_val;
  logic                                  code_neg;
  logic [mre_pkg::CODE_W-1:0]            code_mag;

  logic                                  out_free;
  logic                                  emit;
  logic [mre_pkg::BYTE_W-1:0]            emit_byte;
  logic                                  emit_last;
  logic [mre_pkg::BYTE_W-1:0]            fin_byte;
  logic [mre_pkg::CODE_W-1:0]            leg_btn;
  logic [mre_pkg::POS_W-1:0]             leg_col, leg_row;
  logic [3:0]                            top_digit;

  assign s_tready  = (state == mre_pkg::S_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign in_kind   = mre_pkg::kind_t'(s_tuser);
  assign in_btn    = s_tdata[39:32];

  // button code: number minus one, fourth button upward shifted up
  always_comb begin
    if (in_btn == '0) begin
      in_code = -10'sd1;
    end else if (in_btn > mre_pkg::BTN_W'(mre_pkg::HIGH_BTN)) begin
      in_code = signed'({2'b00, in_btn} + mre_pkg::CODE_W'(mre_pkg::HIGH_SHIFT - 1));
    end else begin
      in_code = signed'({2'b00, in_btn} - 10'd1);
    end
  end

  always_comb begin
    accept_ok = 1'b0;
    case (in_kind)
      mre_pkg::EV_PRESS:   accept_ok = report_press;
      mre_pkg::EV_RELEASE: accept_ok = report_release;
      mre_pkg::EV_MOTION:  accept_ok = report_motion;
      default:             accept_ok = 1'b0;
    endcase
    accept_ok = accept_ok && mouse_enable;
  end

  // a zero cell size divides as one
  assign cw_eff = (cell_width == '0) ? mre_pkg::DIV_W'(1) : cell_width;
  assign ch_eff = (cell_height == '0) ? mre_pkg::DIV_W'(1) : cell_height;

  mre_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (px_r),
    .divisor  (cw_eff),
    .status   (x_status),
    .quotient (x_quo)
  );

  mre_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (py_r),
    .divisor  (ch_eff),
    .status   (y_status),
    .quotient (y_quo)
  );

  assign div_done  = x_status.done && y_status.done;
  assign col_q     = {1'b0, x_quo} + mre_pkg::POS_W'(1);
  assign row_q     = {1'b0, y_quo} + mre_pkg::POS_W'(1);
  assign same_cell = (signed'({1'b0, row_q}) == saved_row) &&
                     (signed'({1'b0, col_q}) == saved_col);

  assign code_neg = code_r[mre_pkg::CODE_W-1];
  assign code_mag = code_neg ? mre_pkg::CODE_W'(-code_r) : mre_pkg::CODE_W'(code_r);

  always_comb begin
    case (fsel)
      mre_pkg::F_BUTTON: conv_val = mre_pkg::POS_W'(code_mag);
      mre_pkg::F_COL:    conv_val = col_r;
      default:           conv_val = row_r;
    endcase
  end

  mre_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (bcd_start),
    .value  (conv_val),
    .status (bcd_status),
    .bcd    (bcd_val)
  );

  assign out_free  = !m_tvalid || m_tready;
  assign fin_byte  = (kind_r == mre_pkg::EV_RELEASE) ? mre_pkg::CH_LOWM : mre_pkg::CH_UPM;
  assign leg_btn   = code_r + mre_pkg::CODE_W'(mre_pkg::CODE_OFS);
  assign leg_col   = col_r + mre_pkg::POS_W'(mre_pkg::CODE_OFS);
  assign leg_row   = row_r + mre_pkg::POS_W'(mre_pkg::CODE_OFS);
  assign top_digit = digits[mre_pkg::BCD_W-1 -: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mre_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    fsel_next    = fsel;
    dcnt_next    = dcnt;
    started_next = started;
    digits_next  = digits;
    div_start    = 1'b0;
    bcd_start    = 1'b0;
    emit         = 1'b0;
    emit_byte    = '0;
    emit_last    = 1'b0;
    unique case (state)
      mre_pkg::S_IDLE: begin
        if (in_accept && accept_ok) begin
          state_next = mre_pkg::S_DIV_GO;
        end
      end
      mre_pkg::S_DIV_GO: begin
        div_start  = 1'b1;
        state_next = mre_pkg::S_DIV_WAIT;
      end
      mre_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          if (kind_r == mre_pkg::EV_MOTION && same_cell) begin
            state_next = mre_pkg::S_IDLE;
          end else begin
            idx_next   = '0;
            state_next = mre_pkg::S_HEAD;
          end
        end
      end
      mre_pkg::S_HEAD: begin
        if (out_free) begin
          emit = 1'b1;
          case (idx)
            2'd0:    emit_byte = mre_pkg::CH_ESC;
            2'd1:    emit_byte = mre_pkg::CH_LBRK;
            default: emit_byte = sgr_format ? mre_pkg::CH_LT : mre_pkg::CH_UPM;
          endcase
          if (idx == 2'd2) begin
            idx_next   = '0;
            fsel_next  = mre_pkg::F_BUTTON;
            state_next = sgr_format ? mre_pkg::S_CONV_GO : mre_pkg::S_LEGACY;
          end else begin
            idx_next = idx + 2'd1;
          end
        end
      end
      mre_pkg::S_LEGACY: begin
        if (out_free) begin
          emit = 1'b1;
          case (idx)
            2'd0:    emit_byte = leg_btn[mre_pkg::BYTE_W-1:0];
            2'd1:    emit_byte = leg_col[mre_pkg::BYTE_W-1:0];
            default: begin
              emit_byte = leg_row[mre_pkg::BYTE_W-1:0];
              emit_last = 1'b1;
            end
          endcase
          if (idx == 2'd2) begin
            state_next = mre_pkg::S_IDLE;
          end else begin
            idx_next = idx + 2'd1;
          end
        end
      end
      mre_pkg::S_CONV_GO: begin
        bcd_start  = 1'b1;
        state_next = mre_pkg::S_CONV_WAIT;
      end
      mre_pkg::S_CONV_WAIT: begin
        if (bcd_status.done) begin
          digits_next  = bcd_val;
          dcnt_next    = '0;
          started_next = 1'b0;
          state_next   = (fsel == mre_pkg::F_BUTTON && code_neg) ? mre_pkg::S_SIGN
                                                                  : mre_pkg::S_DIGITS;
        end
      end
      mre_pkg::S_SIGN: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_byte  = mre_pkg::CH_MINUS;
          state_next = mre_pkg::S_DIGITS;
        end
      end
      mre_pkg::S_DIGITS: begin
        // leading zeros are skipped, the units digit always goes out
        if (top_digit == 4'd0 && !started &&
            dcnt != DCNT_W'(mre_pkg::BCD_DIGITS - 1)) begin
          digits_next = {digits[mre_pkg::BCD_W-5:0], 4'd0};
          dcnt_next   = dcnt + 1'b1;
        end else if (out_free) begin
          emit         = 1'b1;
          emit_byte    = mre_pkg::CH_ZERO + {4'd0, top_digit};
          started_next = 1'b1;
          digits_next  = {digits[mre_pkg::BCD_W-5:0], 4'd0};
          dcnt_next    = dcnt + 1'b1;
          if (dcnt == DCNT_W'(mre_pkg::BCD_DIGITS - 1)) begin
            state_next = mre_pkg::S_SEP;
          end
        end
      end
      mre_pkg::S_SEP: begin
        if (out_free) begin
          emit = 1'b1;
          if (fsel == mre_pkg::F_ROW) begin
            emit_byte  = fin_byte;
            emit_last  = 1'b1;
            state_next = mre_pkg::S_IDLE;
          end else begin
            emit_byte  = mre_pkg::CH_SEMI;
            fsel_next  = (fsel == mre_pkg::F_BUTTON) ? mre_pkg::F_COL : mre_pkg::F_ROW;
            state_next = mre_pkg::S_CONV_GO;
          end
        end
      end
      default: state_next = mre_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    fsel    <= fsel_next;
    dcnt    <= dcnt_next;
    started <= started_next;
    digits  <= digits_next;
  end

  // event payload and cell results
  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= in_kind;
      px_r   <= s_tdata[15:0];
      py_r   <= s_tdata[31:16];
      code_r <= in_code;
    end else if (state == mre_pkg::S_DIV_WAIT && div_done) begin
      col_r <= col_q;
      row_r <= row_q;
      if (kind_r == mre_pkg::EV_MOTION) begin
        code_r <= saved_button + mre_pkg::CODE_W'(mre_pkg::CODE_OFS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_row    <= '1;
      saved_col    <= '1;
      saved_button <= '1;
    end else if (state == mre_pkg::S_DIV_WAIT && div_done) begin
      if (kind_r == mre_pkg::EV_PRESS) begin
        saved_row    <= signed'({1'b0, row_q});
        saved_col    <= signed'({1'b0, col_q});
        saved_button <= code_r;
      end else if (kind_r == mre_pkg::EV_MOTION && !same_cell) begin
        saved_row <= signed'({1'b0, row_q});
        saved_col <= signed'({1'b0, col_q});
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_byte;
      m_tlast <= emit_last;
    end
  end

endmodule

FILE: src/mre_div.sv
module mre_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [mre_pkg::COORD_W-1:0]       dividend,
  input  logic [mre_pkg::DIV_W-1:0]         divisor,
  output mre_pkg::unit_status_t             status,
  output logic [mre_pkg::COORD_W-1:0]       quotient
);

  localparam int CNT_W = $clog2(mre_pkg::COORD_W);

  logic                          busy;
  logic                          done;
  logic [CNT_W-1:0]              cnt;
  logic [mre_pkg::DIV_W-1:0]     rem;
  logic [mre_pkg::DIV_W-1:0]     dvs;
  logic [mre_pkg::COORD_W-1:0]   quo;
  logic [mre_pkg::DIV_W:0]       shifted;
  logic [mre_pkg::DIV_W:0]       diff;
  logic                          ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem, quo[mre_pkg::COORD_W-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = ge ? (shifted - {1'b0, dvs}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(mre_pkg::COORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= diff[mre_pkg::DIV_W-1:0];
      quo <= {quo[mre_pkg::COORD_W-2:0], ge};
    end
  end

  assign status.done = done;
  assign quotient    = quo;

endmodule

FILE: src/mre_bcd.sv
module mre_bcd (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [mre_pkg::POS_W-1:0]     value,
  output mre_pkg::unit_status_t         status,
  output logic [mre_pkg::BCD_W-1:0]     bcd
);

  localparam int CNT_W = $clog2(mre_pkg::POS_W);

  logic                          busy;
  logic                          done;
  logic [CNT_W-1:0]              cnt;
  logic [mre_pkg::POS_W-1:0]     bin;
  logic [mre_pkg::BCD_W-1:0]     acc;
  logic [mre_pkg::BCD_W-1:0]     adj;

  // shift-and-add-3, one binary bit enters per cycle
  always_comb begin
    for (int i = 0; i < mre_pkg::BCD_DIGITS; i++) begin
      adj[4*i +: 4] = (acc[4*i +: 4] >= 4'd5) ? (acc[4*i +: 4] + 4'd3) : acc[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(mre_pkg::POS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      acc <= '0;
    end else if (busy) begin
      acc <= {adj[mre_pkg::BCD_W-2:0], bin[mre_pkg::POS_W-1]};
      bin <= {bin[mre_pkg::POS_W-2:0], 1'b0};
    end
  end

  assign status.done = done;
  assign bcd         = acc;

endmodule

FILE: sim/mouse_report_encoder_unit_tb.sv
module mouse_report_encoder_unit_tb;

  localparam int HOLD_CYCLES    = 200;   // covers a silent event still in progress
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_SENDS    = 75;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [39:0]                    s_tdata   = '0;  // pointer_x, pointer_y, button_number
  logic [1:0]                     s_tuser   = '0;  // event_kind
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [7:0]                     m_tdata;         // out_byte
  logic                           m_tlast;         // last_byte
  logic                           cfg_we    = 1'b0;
  logic [mre_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mre_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  mouse_report_encoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } seq_byte_t;

  // expected escape sequence bytes, oldest first
  seq_byte_t seq_bytes_q[$];

  // shadow of the configuration and the saved pointer state
  logic [7:0]                             cell_w_sh;
  logic [7:0]                             cell_h_sh;
  logic                                   mouse_en_sh;
  logic                                   press_en_sh;
  logic                                   release_en_sh;
  logic                                   motion_en_sh;
  logic                                   sgr_sh;
  logic signed [mre_pkg::SAVED_POS_W-1:0] saved_row_sh;
  logic signed [mre_pkg::SAVED_POS_W-1:0] saved_col_sh;
  logic signed [mre_pkg::CODE_W-1:0]      saved_code_sh;

  int errors       = 0;
  int idle_pct     = 0;
  int stall_pct    = 0;
  int sent_events  = 0;
  int quiet_cycles = 0;

  function automatic void push_seq_byte(input logic [7:0] v, input logic l);
    seq_byte_t sb;
    sb.data = v;
    sb.last = l;
    seq_bytes_q.push_back(sb);
  endfunction

  function automatic void push_decimal(input int v);
    int u;
    int digs[10];
    int k;
    k = 0;
    if (v < 0) begin
      push_seq_byte(mre_pkg::CH_MINUS, 1'b0);
      u = -v;
    end else begin
      u = v;
    end
    do begin
      digs[k] = u % 10;
      k++;
      u = u / 10;
    end while (u != 0);
    while (k > 0) begin
      k--;
      push_seq_byte(8'(int'(mre_pkg::CH_ZERO) + digs[k]), 1'b0);
    end
  endfunction

  // returns the number of bytes the event produces
  function automatic int encode_event(input mre_pkg::kind_t kind, input logic [15:0] px,
                                      input logic [15:0] py, input logic [7:0] btn);
    int cw;
    int ch;
    int row;
    int col;
    int code;
    int n0;
    logic [7:0] fin;
    cw = (cell_w_sh == 0) ? 1 : int'(cell_w_sh);
    ch = (cell_h_sh == 0) ? 1 : int'(cell_h_sh);
    row = int'(py) / ch + 1;
    col = int'(px) / cw + 1;
    code = int'(btn) - 1;
    if (code >= mre_pkg::HIGH_BTN) code += mre_pkg::HIGH_SHIFT;
    if (!mouse_en_sh) return 0;
    case (kind)
      mre_pkg::EV_PRESS: begin
        if (!press_en_sh) return 0;
        fin = mre_pkg::CH_UPM;
        saved_row_sh  = mre_pkg::SAVED_POS_W'(row);
        saved_col_sh  = mre_pkg::SAVED_POS_W'(col);
        saved_code_sh = mre_pkg::CODE_W'(code);
      end
      mre_pkg::EV_RELEASE: begin
        if (!release_en_sh) return 0;
        fin = mre_pkg::CH_LOWM;
      end
      mre_pkg::EV_MOTION: begin
        if (!motion_en_sh) return 0;
        if (row == int'(saved_row_sh) && col == int'(saved_col_sh)) return 0;
        fin = mre_pkg::CH_UPM;
        saved_row_sh = mre_pkg::SAVED_POS_W'(row);
        saved_col_sh = mre_pkg::SAVED_POS_W'(col);
        code = int'(saved_code_sh) + mre_pkg::CODE_OFS;
      end
      default: return 0;
    endcase
    n0 = seq_bytes_q.size();
    push_seq_byte(mre_pkg::CH_ESC, 1'b0);
    push_seq_byte(mre_pkg::CH_LBRK, 1'b0);
    if (sgr_sh) begin
      push_seq_byte(mre_pkg::CH_LT, 1'b0);
      push_decimal(code);
      push_seq_byte(mre_pkg::CH_SEMI, 1'b0);
      push_decimal(col);
      push_seq_byte(mre_pkg::CH_SEMI, 1'b0);
      push_decimal(row);
      push_seq_byte(fin, 1'b1);
    end else begin
      push_seq_byte(mre_pkg::CH_UPM, 1'b0);
      push_seq_byte(8'(code + mre_pkg::CODE_OFS), 1'b0);
      push_seq_byte(8'(col + mre_pkg::CODE_OFS), 1'b0);
      push_seq_byte(8'(row + mre_pkg::CODE_OFS), 1'b1);
    end
    return seq_bytes_q.size() - n0;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t: %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  // output side checker
  always @(posedge clk) begin
    seq_byte_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (seq_bytes_q.size() == 0) begin
        report_mismatch("beat with nothing pending", m_tdata, 8'h00);
      end else begin
        want = seq_bytes_q.pop_front();
        if (m_tdata !== want.data) report_mismatch("out_byte", m_tdata, want.data);
        if (m_tlast !== want.last) report_mismatch("last_byte", 8'(m_tlast), 8'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("mouse_report_encoder_unit: mismatch");
        $finish;
      end
    end
  end

  task automatic write_reg(input mre_pkg::cfg_reg_t idx, input logic [7:0] v);
    s_tvalid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      mre_pkg::REG_CELL_WIDTH:     cell_w_sh     = v;
      mre_pkg::REG_CELL_HEIGHT:    cell_h_sh     = v;
      mre_pkg::REG_MOUSE_ENABLE:   mouse_en_sh   = v[0];
      mre_pkg::REG_REPORT_PRESS:   press_en_sh   = v[0];
      mre_pkg::REG_REPORT_RELEASE: release_en_sh = v[0];
      mre_pkg::REG_REPORT_MOTION:  motion_en_sh  = v[0];
      mre_pkg::REG_SGR_FORMAT:     sgr_sh        = v[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_event(input mre_pkg::kind_t kind, input logic [15:0] px,
                            input logic [15:0] py, input logic [7:0] btn);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {btn, py, px};
    do @(posedge clk); while (!s_tready);
    sent_events++;
    void'(encode_event(kind, px, py, btn));
  endtask

  task automatic wait_reports_done();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (seq_bytes_q.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_reports_done();
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_cell_size();
    case ($urandom_range(4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      default: return 8'($urandom_range(2, 254));
    endcase
  endfunction

  // bit 0 carries the flag, upper bits are noise the block must ignore
  function automatic logic [7:0] rand_flag(input int pct_on);
    return {7'($urandom_range(127)), 1'($urandom_range(99) < pct_on)};
  endfunction

  function automatic logic [7:0] rand_button();
    if ($urandom_range(9) < 7) return 8'($urandom_range(1, 5));
    return 8'($urandom_range(255));
  endfunction

  // with reporting off nothing comes out and the saved state stays at reset
  task automatic test_masked_events();
    send_event(mre_pkg::EV_PRESS, 16'd100, 16'd100, 8'd1);
    send_event(mre_pkg::EV_MOTION, 16'd300, 16'd50, 8'd2);
    send_event(mre_pkg::EV_RELEASE, 16'd0, 16'd0, 8'd1);
    write_reg(mre_pkg::REG_MOUSE_ENABLE, 8'h01);
    send_event(mre_pkg::EV_PRESS, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_event(mre_pkg::EV_OTHER, 16'h1234, 16'h5678, 8'h9A);
    wait_idle();
  endtask

  task automatic test_legacy_form();
    write_reg(mre_pkg::REG_REPORT_PRESS, 8'h01);
    write_reg(mre_pkg::REG_REPORT_RELEASE, 8'h01);
    write_reg(mre_pkg::REG_REPORT_MOTION, 8'h01);
    // motion before any press uses the reset button code
    send_event(mre_pkg::EV_MOTION, 16'd0, 16'd0, 8'd3);
    send_event(mre_pkg::EV_MOTION, 16'd7, 16'd15, 8'd3);     // same cell, dropped
    send_event(mre_pkg::EV_PRESS, 16'd7, 16'd15, 8'd1);
    send_event(mre_pkg::EV_RELEASE, 16'd9, 16'd17, 8'd2);
    send_event(mre_pkg::EV_PRESS, 16'd8, 16'd16, 8'd4);       // high-button shift
    send_event(mre_pkg::EV_MOTION, 16'd100, 16'd200, 8'd1);
    send_event(mre_pkg::EV_PRESS, 16'd40, 16'd40, 8'd0);      // button zero
    send_event(mre_pkg::EV_PRESS, 16'hFFFF, 16'hFFFF, 8'hFF); // bytes wrap
    send_event(mre_pkg::EV_OTHER, 16'hFFFF, 16'h0000, 8'hFF);
    send_event(mre_pkg::EV_RELEASE, 16'h0000, 16'hFFFF, 8'hFF);
    wait_idle();
  endtask

  task automatic test_sgr_form();
    write_reg(mre_pkg::REG_SGR_FORMAT, 8'h01);
    write_reg(mre_pkg::REG_CELL_WIDTH, 8'd0);   // zero divides as one
    write_reg(mre_pkg::REG_CELL_HEIGHT, 8'd1);
    send_event(mre_pkg::EV_PRESS, 16'hFFFF, 16'hFFFF, 8'hFF);
    // longest sequence: three digit code and two five digit positions
    send_event(mre_pkg::EV_MOTION, 16'hFFFE, 16'hFFFF, 8'd1);
    send_event(mre_pkg::EV_PRESS, 16'd0, 16'd0, 8'd0);
    send_event(mre_pkg::EV_RELEASE, 16'd5, 16'd5, 8'd3);
    send_event(mre_pkg::EV_RELEASE, 16'd5, 16'd5, 8'd4);
    send_event(mre_pkg::EV_OTHER, 16'd1, 16'd1, 8'd1);
    wait_idle();
    write_reg(mre_pkg::REG_CELL_WIDTH, 8'd255);
    write_reg(mre_pkg::REG_CELL_HEIGHT, 8'd255);
    send_event(mre_pkg::EV_MOTION, 16'hFFFF, 16'd0, 8'd1);
    send_event(mre_pkg::EV_PRESS, 16'd254, 16'd254, 8'd1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int idles[4]  = '{0, 60, 0, 24};
    int stalls[4] = '{0, 0, 60, 24};
    logic [15:0] px;
    logic [15:0] py;
    logic [7:0]  btn;
    int span_x;
    int span_y;
    int moves;
    int start_sends;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(mre_pkg::REG_CELL_WIDTH, rand_cell_size());
      write_reg(mre_pkg::REG_CELL_HEIGHT, rand_cell_size());
      write_reg(mre_pkg::REG_MOUSE_ENABLE, rand_flag(90));
      write_reg(mre_pkg::REG_REPORT_PRESS, rand_flag(85));
      write_reg(mre_pkg::REG_REPORT_RELEASE, rand_flag(80));
      write_reg(mre_pkg::REG_REPORT_MOTION, rand_flag(85));
      write_reg(mre_pkg::REG_SGR_FORMAT, rand_flag(50));
      idle_pct    = idles[ph];
      stall_pct   = stalls[ph];
      start_sends = sent_events;
      while (sent_events - start_sends < PHASE_SENDS) begin
        px = 16'($urandom_range(65535));
        py = 16'($urandom_range(65535));
        btn = rand_button();
        span_x = int'(cell_w_sh) + 2;
        span_y = int'(cell_h_sh) + 2;
        case ($urandom_range(9))
          0: send_event(mre_pkg::kind_t'($urandom_range(3)), px, py, 8'($urandom_range(255)));
          1: send_event($urandom_range(1) ? mre_pkg::EV_MOTION : mre_pkg::EV_RELEASE,
                        px, py, btn);
          default: begin
            // press, drag with small steps, release
            send_event(mre_pkg::EV_PRESS, px, py, btn);
            moves = $urandom_range(5);
            repeat (moves) begin
              px = px + 16'($urandom_range(2 * span_x) - span_x);
              py = py + 16'($urandom_range(2 * span_y) - span_y);
              send_event(mre_pkg::EV_MOTION, px, py, rand_button());
            end
            send_event(mre_pkg::EV_RELEASE, px, py, btn);
          end
        endcase
        if ($urandom_range(49) == 0) wait_reports_done();
      end
      wait_idle();
    end
  endtask

  initial begin
    cell_w_sh     = 8'd8;
    cell_h_sh     = 8'd16;
    mouse_en_sh   = 1'b0;
    press_en_sh   = 1'b0;
    release_en_sh = 1'b0;
    motion_en_sh  = 1'b0;
    sgr_sh        = 1'b0;
    saved_row_sh  = '1;
    saved_col_sh  = '1;
    saved_code_sh = '1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_masked_events();
    test_legacy_form();
    test_sgr_form();
    test_random_traffic();
    idle_pct  = 0;
    stall_pct = 0;
    wait_idle();
    if (errors == 0) begin
      $display("mouse_report_encoder_unit: match");
    end else begin
      $display("mouse_report_encoder_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: mouse_report_encoder_unit.f
src/mre_pkg.sv
src/mre_div.sv
src/mre_bcd.sv
src/mouse_report_encoder_unit.sv
sim/mouse_report_encoder_unit_tb.sv
